### design/tsnm_pkg.sv
// Shared types, constants and register indexes for the tangent-space normal map core.
// Depends on nothing; every other design file imports it.
package tsnm_pkg;

    // Width of a vector component entering the normalising pipeline.
    localparam int NORM_W     = 56;
    // Bit-serial square root: one result bit per stage.
    localparam int SQRT_STEPS = 31;
    // Restoring division: one quotient bit per stage.
    localparam int DIV_STEPS  = 16;
    // Register stages through one normaliser.
    localparam int NORM_LAT   = 5 + SQRT_STEPS + DIV_STEPS + 1;

    localparam logic signed [15:0] Q14_ONE  = 16'sd16384;
    localparam logic signed [15:0] Q14_HALF = 16'sd8192;
    localparam logic [15:0]        Q14_MAX  = 16'd32767;

    typedef enum logic [2:0] {
        REG_DISABLE   = 3'd0,
        REG_NORMAL    = 3'd1,
        REG_TANGENT   = 3'd2,
        REG_BITANGENT = 3'd3,
        REG_SCALE_X   = 3'd4,
        REG_SCALE_Y   = 3'd5,
        REG_EPSILON   = 3'd6
    } reg_idx_t;

    typedef logic [2:0][15:0] vec16_t;
    typedef logic [2:0][17:0] vec18_t;

    typedef struct packed {
        logic        disable_mode;
        logic        normal_default;
        logic        tangent_default;
        logic        bitangent_default;
        logic [15:0] scale_x;
        logic [15:0] scale_y;
        logic [31:0] epsilon_threshold;
    } cfg_t;

endpackage

### design/tsnm_cfg.sv
// Configuration register file of the tangent-space normal map core, on an APB-style port.
// Depends on tsnm_pkg for the register indexes and the cfg_t bundle.
module tsnm_cfg import tsnm_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    output cfg_t        cfg
);

    cfg_t cfg_reg;
    logic wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel & penable & pwrite;
    assign cfg    = cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.disable_mode      <= 1'b0;
            cfg_reg.normal_default    <= 1'b1;
            cfg_reg.tangent_default   <= 1'b1;
            cfg_reg.bitangent_default <= 1'b1;
            cfg_reg.scale_x           <= 16'd4096;
            cfg_reg.scale_y           <= 16'd4096;
            cfg_reg.epsilon_threshold <= 32'd16;
        end else if (wr_en) begin
            case (paddr[4:2])
                REG_DISABLE:   cfg_reg.disable_mode      <= pwdata[0];
                REG_NORMAL:    cfg_reg.normal_default    <= pwdata[0];
                REG_TANGENT:   cfg_reg.tangent_default   <= pwdata[0];
                REG_BITANGENT: cfg_reg.bitangent_default <= pwdata[0];
                REG_SCALE_X:   cfg_reg.scale_x           <= pwdata[15:0];
                REG_SCALE_Y:   cfg_reg.scale_y           <= pwdata[15:0];
                REG_EPSILON:   cfg_reg.epsilon_threshold <= pwdata;
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[4:2])
            REG_DISABLE:   prdata = {31'd0, cfg_reg.disable_mode};
            REG_NORMAL:    prdata = {31'd0, cfg_reg.normal_default};
            REG_TANGENT:   prdata = {31'd0, cfg_reg.tangent_default};
            REG_BITANGENT: prdata = {31'd0, cfg_reg.bitangent_default};
            REG_SCALE_X:   prdata = {16'd0, cfg_reg.scale_x};
            REG_SCALE_Y:   prdata = {16'd0, cfg_reg.scale_y};
            REG_EPSILON:   prdata = cfg_reg.epsilon_threshold;
            default:       prdata = 32'd0;
        endcase
    end

endmodule

### design/tsnm_norm3.sv
// Pipelined three-component normaliser: scale, sum of squares, bit-serial square root
// and restoring division, NORM_LAT stages. Depends on tsnm_pkg.
module tsnm_norm3 import tsnm_pkg::*; (
    input  logic                    aclk,
    input  logic                    en,
    input  logic [2:0][NORM_W-1:0]  vec_in,
    output vec16_t                  vec_out
);

    // Magnitudes and the OR of them; the OR has the same leading one as the largest.
    logic [2:0][NORM_W-1:0] p1_mag_next, p1_mag_reg;
    logic [2:0]             p1_neg_reg;
    logic [NORM_W-1:0]      p1_or_next, p1_or_reg;

    logic [2:0][NORM_W-1:0] p2_mag_reg;
    logic [2:0]             p2_neg_reg;
    logic [5:0]             p2_lead_next, p2_lead_reg;
    logic                   p2_zero_reg;

    logic [2:0][29:0]       p3_mag_next, p3_mag_reg;
    logic [2:0]             p3_neg_reg;
    logic                   p3_zero_reg;

    logic [2:0][59:0]       p4_sq_next, p4_sq_reg;
    logic [2:0][29:0]       p4_mag_reg;
    logic [2:0]             p4_neg_reg;
    logic                   p4_zero_reg;

    logic [61:0]            p5_sum_reg;
    logic [2:0][29:0]       p5_mag_reg;
    logic [2:0]             p5_neg_reg;
    logic                   p5_zero_reg;

    logic [61:0]            rt_x_reg    [SQRT_STEPS];
    logic [61:0]            rt_r_reg    [SQRT_STEPS];
    logic [2:0][29:0]       rt_mag_reg  [SQRT_STEPS];
    logic [2:0]             rt_neg_reg  [SQRT_STEPS];
    logic                   rt_zero_reg [SQRT_STEPS];

    logic [2:0][47:0]       dv_rem_reg  [DIV_STEPS];
    logic [2:0][15:0]       dv_q_reg    [DIV_STEPS];
    logic [31:0]            dv_den_reg  [DIV_STEPS];
    logic [2:0]             dv_neg_reg  [DIV_STEPS];
    logic                   dv_zero_reg [DIV_STEPS];

    vec16_t                 out_next, out_reg;

    always_comb begin
        p1_or_next = '0;
        for (int i = 0; i < 3; i++) begin
            p1_mag_next[i] = vec_in[i][NORM_W-1] ? (NORM_W'(0) - vec_in[i]) : vec_in[i];
            p1_or_next     = p1_or_next | p1_mag_next[i];
        end
    end

    always_comb begin
        p2_lead_next = '0;
        for (int i = 0; i < NORM_W; i++) begin
            if (p1_or_reg[i]) begin
                p2_lead_next = 6'(i);
            end
        end
    end

    // Bring the largest magnitude into [2^29, 2^30).
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            if (p2_lead_reg >= 6'd29) begin
                p3_mag_next[i] = 30'(p2_mag_reg[i] >> (p2_lead_reg - 6'd29));
            end else begin
                p3_mag_next[i] = 30'(p2_mag_reg[i] << (6'd29 - p2_lead_reg));
            end
        end
    end

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            p4_sq_next[i] = 60'(p3_mag_reg[i]) * 60'(p3_mag_reg[i]);
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            p1_mag_reg  <= p1_mag_next;
            p1_neg_reg  <= {vec_in[2][NORM_W-1], vec_in[1][NORM_W-1], vec_in[0][NORM_W-1]};
            p1_or_reg   <= p1_or_next;
            p2_mag_reg  <= p1_mag_reg;
            p2_neg_reg  <= p1_neg_reg;
            p2_lead_reg <= p2_lead_next;
            p2_zero_reg <= ~|p1_or_reg;
            p3_mag_reg  <= p3_mag_next;
            p3_neg_reg  <= p2_neg_reg;
            p3_zero_reg <= p2_zero_reg;
            p4_sq_reg   <= p4_sq_next;
            p4_mag_reg  <= p3_mag_reg;
            p4_neg_reg  <= p3_neg_reg;
            p4_zero_reg <= p3_zero_reg;
            p5_sum_reg  <= 62'(p4_sq_reg[0]) + 62'(p4_sq_reg[1]) + 62'(p4_sq_reg[2]);
            p5_mag_reg  <= p4_mag_reg;
            p5_neg_reg  <= p4_neg_reg;
            p5_zero_reg <= p4_zero_reg;
        end
    end

    // Square root, one result bit per stage.
    for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_sqrt
        logic [61:0]      x_in, r_in, bit_val, trial, x_next, r_next;
        logic [2:0][29:0] mag_in;
        logic [2:0]       neg_in;
        logic             zero_in;

        if (k == 0) begin : g_first
            assign x_in    = p5_sum_reg;
            assign r_in    = '0;
            assign mag_in  = p5_mag_reg;
            assign neg_in  = p5_neg_reg;
            assign zero_in = p5_zero_reg;
        end else begin : g_rest
            assign x_in    = rt_x_reg[k-1];
            assign r_in    = rt_r_reg[k-1];
            assign mag_in  = rt_mag_reg[k-1];
            assign neg_in  = rt_neg_reg[k-1];
            assign zero_in = rt_zero_reg[k-1];
        end

        assign bit_val = 62'(1) << (2 * (SQRT_STEPS - 1 - k));
        assign trial   = r_in + bit_val;

        always_comb begin
            if (x_in >= trial) begin
                x_next = x_in - trial;
                r_next = (r_in >> 1) + bit_val;
            end else begin
                x_next = x_in;
                r_next = r_in >> 1;
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                rt_x_reg[k]    <= x_next;
                rt_r_reg[k]    <= r_next;
                rt_mag_reg[k]  <= mag_in;
                rt_neg_reg[k]  <= neg_in;
                rt_zero_reg[k] <= zero_in;
            end
        end
    end

    // Quotient round-half-up(mag * 2^14 / len) as floor((mag * 2^15 + len) / (2 * len)).
    for (genvar j = 0; j < DIV_STEPS; j++) begin : g_div
        logic [2:0][47:0] rem_in, rem_next;
        logic [2:0][15:0] q_in, q_next;
        logic [31:0]      den_in;
        logic [47:0]      den_sh;
        logic [2:0]       neg_in;
        logic             zero_in;

        if (j == 0) begin : g_first
            logic [30:0] len;
            assign len    = rt_r_reg[SQRT_STEPS-1][30:0];
            assign den_in = {len, 1'b0};
            assign q_in   = '0;
            for (genvar i = 0; i < 3; i++) begin : g_num
                assign rem_in[i] = (48'(rt_mag_reg[SQRT_STEPS-1][i]) << 15) + 48'(len);
            end
            assign neg_in  = rt_neg_reg[SQRT_STEPS-1];
            assign zero_in = rt_zero_reg[SQRT_STEPS-1];
        end else begin : g_rest
            assign rem_in  = dv_rem_reg[j-1];
            assign q_in    = dv_q_reg[j-1];
            assign den_in  = dv_den_reg[j-1];
            assign neg_in  = dv_neg_reg[j-1];
            assign zero_in = dv_zero_reg[j-1];
        end

        assign den_sh = 48'(den_in) << (DIV_STEPS - 1 - j);

        always_comb begin
            for (int i = 0; i < 3; i++) begin
                q_next[i] = q_in[i];
                if (rem_in[i] >= den_sh) begin
                    rem_next[i]                  = rem_in[i] - den_sh;
                    q_next[i][DIV_STEPS - 1 - j] = 1'b1;
                end else begin
                    rem_next[i] = rem_in[i];
                end
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                dv_rem_reg[j]  <= rem_next;
                dv_q_reg[j]    <= q_next;
                dv_den_reg[j]  <= den_in;
                dv_neg_reg[j]  <= neg_in;
                dv_zero_reg[j] <= zero_in;
            end
        end
    end

    always_comb begin
        logic [15:0] q;
        for (int i = 0; i < 3; i++) begin
            q = (dv_q_reg[DIV_STEPS-1][i] > Q14_MAX) ? Q14_MAX : dv_q_reg[DIV_STEPS-1][i];
            if (dv_zero_reg[DIV_STEPS-1]) begin
                out_next[i] = '0;
            end else if (dv_neg_reg[DIV_STEPS-1][i]) begin
                out_next[i] = 16'd0 - q;
            end else begin
                out_next[i] = q;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            out_reg <= out_next;
        end
    end

    assign vec_out = out_reg;

endmodule

### design/tangent_space_normal_map_core.sv
// Tangent-space normal map core: texel plus surface frame in, world-space normal out.
// Depends on tsnm_pkg, tsnm_cfg and tsnm_norm3.
//
// The core takes one request per clock while s_ready is high and returns one result per
// request, in order. Its depth is set by three normalisers in series (surface normal and
// tangent side by side, then the derived bitangent, then the combined vector), each 53
// stages deep because the square root and the division both resolve one bit per stage;
// the remaining stages cover the input register, the texel length test and remap, the
// cross product, the three-way combination, the final select and the output register.
// Every stage holds a valid bit and the whole pipeline advances together;
// a skid register behind the output register lets the core keep accepting requests while
// one result waits, and s_ready only drops once that skid register is occupied. The
// configuration registers are read directly by the datapath, so they must only be
// written while no request is in flight.
module tangent_space_normal_map_core import tsnm_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [15:0] s_texel_x,
    input  logic [15:0] s_texel_y,
    input  logic [15:0] s_texel_z,
    input  logic [15:0] s_normal_x,
    input  logic [15:0] s_normal_y,
    input  logic [15:0] s_normal_z,
    input  logic [15:0] s_tangent_x,
    input  logic [15:0] s_tangent_y,
    input  logic [15:0] s_tangent_z,
    input  logic [15:0] s_bitangent_x,
    input  logic [15:0] s_bitangent_y,
    input  logic [15:0] s_bitangent_z,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [15:0] m_result_x,
    output logic [15:0] m_result_y,
    output logic [15:0] m_result_z,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    // Side data carried alongside the first pair of normalisers.
    typedef struct packed {
        vec16_t tex;
        vec18_t tx2;
        vec16_t n;
        vec16_t t;
        vec16_t b;
    } side1_t;

    // Side data carried alongside the bitangent normaliser.
    typedef struct packed {
        vec16_t tex;
        vec18_t tx2;
        vec16_t n;
        vec16_t t;
        vec16_t b;
    } side2_t;

    cfg_t cfg;
    logic en;

    tsnm_cfg u_cfg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // Stage 0: input register.
    logic   s0_valid_reg;
    vec16_t s0_tex_reg, s0_n_reg, s0_t_reg, s0_b_reg;

    // Stage 1: squared texel length.
    logic        s1_valid_reg;
    logic [31:0] s1_len2_next, s1_len2_reg;
    vec16_t      s1_tex_reg, s1_n_reg, s1_t_reg, s1_b_reg;

    // Stage 2: short-texel substitution and remap to 2v-1.
    logic   s2_valid_reg;
    vec18_t s2_tx2_next, s2_tx2_reg;
    vec16_t s2_tex_reg, s2_n_reg, s2_t_reg, s2_b_reg;

    logic [2:0][NORM_W-1:0] nn_in, nt_in, nc_in, na_in;
    vec16_t                 nn_out, nt_out, nc_out, na_out;

    logic [NORM_LAT-1:0] d1_valid_reg;
    side1_t              d1_reg [NORM_LAT];

    // Cross product stage.
    logic             c_valid_reg;
    vec16_t           n_sel, t_sel;
    logic [2:0][32:0] c_cross_next, c_cross_reg;
    side2_t           c_side_reg;

    logic [NORM_LAT-1:0] d2_valid_reg;
    side2_t              d2_reg [NORM_LAT];

    // Combination: scale products, texel products, sum.
    vec16_t           b_sel;
    logic             m1_valid_reg;
    logic [2:0][31:0] m1_ts_next, m1_ts_reg, m1_bs_next, m1_bs_reg;
    logic [2:0][33:0] m1_nz_next, m1_nz_reg;
    logic [17:0]      m1_tx0_reg, m1_tx1_reg;
    vec16_t           m1_tex_reg;

    logic             m2_valid_reg;
    logic [2:0][49:0] m2_ta_next, m2_ta_reg, m2_ba_next, m2_ba_reg;
    vec16_t           m2_tex_reg;

    logic                   m3_valid_reg;
    logic [2:0][NORM_W-1:0] m3_acc_next, m3_acc_reg;
    logic [2:0][33:0]       m2_nz_reg;
    vec16_t                 m3_tex_reg;

    logic [NORM_LAT-1:0] d3_valid_reg;
    vec16_t              d3_tex_reg [NORM_LAT];

    // Final select and output buffering.
    logic   f_valid_reg;
    vec16_t f_res_reg;
    logic   m_valid_reg, skid_valid_reg;
    vec16_t m_res_reg, skid_res_reg;
    logic   push;

    assign en      = ~skid_valid_reg;
    assign s_ready = en;
    assign push    = en & f_valid_reg;

    // Valid bits: the whole pipeline moves on together whenever en is high.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s0_valid_reg <= 1'b0;
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            d1_valid_reg <= '0;
            c_valid_reg  <= 1'b0;
            d2_valid_reg <= '0;
            m1_valid_reg <= 1'b0;
            m2_valid_reg <= 1'b0;
            m3_valid_reg <= 1'b0;
            d3_valid_reg <= '0;
            f_valid_reg  <= 1'b0;
        end else if (en) begin
            s0_valid_reg <= s_valid;
            s1_valid_reg <= s0_valid_reg;
            s2_valid_reg <= s1_valid_reg;
            d1_valid_reg <= {d1_valid_reg[NORM_LAT-2:0], s2_valid_reg};
            c_valid_reg  <= d1_valid_reg[NORM_LAT-1];
            d2_valid_reg <= {d2_valid_reg[NORM_LAT-2:0], c_valid_reg};
            m1_valid_reg <= d2_valid_reg[NORM_LAT-1];
            m2_valid_reg <= m1_valid_reg;
            m3_valid_reg <= m2_valid_reg;
            d3_valid_reg <= {d3_valid_reg[NORM_LAT-2:0], m3_valid_reg};
            f_valid_reg  <= d3_valid_reg[NORM_LAT-1];
        end
    end

    // Squared texel length is exact: each square is at most 2^30.
    always_comb begin
        logic signed [31:0] sq;
        s1_len2_next = '0;
        for (int i = 0; i < 3; i++) begin
            sq           = $signed(s0_tex_reg[i]) * $signed(s0_tex_reg[i]);
            s1_len2_next = s1_len2_next + sq;
        end
    end

    always_comb begin
        vec16_t tex_use;
        if (s1_len2_reg < cfg.epsilon_threshold) begin
            tex_use = {Q14_ONE, Q14_HALF, Q14_HALF};
        end else begin
            tex_use = s1_tex_reg;
        end
        for (int i = 0; i < 3; i++) begin
            s2_tx2_next[i] = {tex_use[i][15], tex_use[i], 1'b0} - 18'(Q14_ONE);
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            s0_tex_reg  <= {s_texel_z, s_texel_y, s_texel_x};
            s0_n_reg    <= {s_normal_z, s_normal_y, s_normal_x};
            s0_t_reg    <= {s_tangent_z, s_tangent_y, s_tangent_x};
            s0_b_reg    <= {s_bitangent_z, s_bitangent_y, s_bitangent_x};
            s1_len2_reg <= s1_len2_next;
            s1_tex_reg  <= s0_tex_reg;
            s1_n_reg    <= s0_n_reg;
            s1_t_reg    <= s0_t_reg;
            s1_b_reg    <= s0_b_reg;
            s2_tx2_reg  <= s2_tx2_next;
            s2_tex_reg  <= s1_tex_reg;
            s2_n_reg    <= s1_n_reg;
            s2_t_reg    <= s1_t_reg;
            s2_b_reg    <= s1_b_reg;
        end
    end

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            nn_in[i] = NORM_W'($signed(s2_n_reg[i]));
            nt_in[i] = NORM_W'($signed(s2_t_reg[i]));
        end
    end

    tsnm_norm3 u_norm_n (.aclk(aclk), .en(en), .vec_in(nn_in), .vec_out(nn_out));
    tsnm_norm3 u_norm_t (.aclk(aclk), .en(en), .vec_in(nt_in), .vec_out(nt_out));

    always_ff @(posedge aclk) begin
        if (en) begin
            d1_reg[0] <= '{tex: s2_tex_reg, tx2: s2_tx2_reg, n: s2_n_reg,
                           t: s2_t_reg, b: s2_b_reg};
            for (int k = 1; k < NORM_LAT; k++) begin
                d1_reg[k] <= d1_reg[k-1];
            end
        end
    end

    assign n_sel = cfg.normal_default  ? nn_out : d1_reg[NORM_LAT-1].n;
    assign t_sel = cfg.tangent_default ? nt_out : d1_reg[NORM_LAT-1].t;

    // Cross product T x N, exact in 33 bits.
    always_comb begin
        logic signed [32:0] pa, pb;
        for (int i = 0; i < 3; i++) begin
            pa = $signed(t_sel[(i + 1) % 3]) * $signed(n_sel[(i + 2) % 3]);
            pb = $signed(t_sel[(i + 2) % 3]) * $signed(n_sel[(i + 1) % 3]);
            c_cross_next[i] = pa - pb;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            c_cross_reg <= c_cross_next;
            c_side_reg  <= '{tex: d1_reg[NORM_LAT-1].tex, tx2: d1_reg[NORM_LAT-1].tx2,
                             n: n_sel, t: t_sel, b: d1_reg[NORM_LAT-1].b};
        end
    end

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            nc_in[i] = NORM_W'($signed(c_cross_reg[i]));
        end
    end

    tsnm_norm3 u_norm_b (.aclk(aclk), .en(en), .vec_in(nc_in), .vec_out(nc_out));

    always_ff @(posedge aclk) begin
        if (en) begin
            d2_reg[0] <= c_side_reg;
            for (int k = 1; k < NORM_LAT; k++) begin
                d2_reg[k] <= d2_reg[k-1];
            end
        end
    end

    assign b_sel = cfg.bitangent_default ? nc_out : d2_reg[NORM_LAT-1].b;

    always_comb begin
        logic signed [31:0] ts, bs;
        logic signed [33:0] nz;
        for (int i = 0; i < 3; i++) begin
            ts = $signed(d2_reg[NORM_LAT-1].t[i]) * $signed(cfg.scale_x);
            bs = $signed(b_sel[i]) * $signed(cfg.scale_y);
            nz = $signed(d2_reg[NORM_LAT-1].n[i]) * $signed(d2_reg[NORM_LAT-1].tx2[2]);
            m1_ts_next[i] = ts;
            m1_bs_next[i] = bs;
            m1_nz_next[i] = nz;
        end
    end

    always_comb begin
        logic signed [49:0] ta, ba;
        for (int i = 0; i < 3; i++) begin
            ta = $signed(m1_ts_reg[i]) * $signed(m1_tx0_reg);
            ba = $signed(m1_bs_reg[i]) * $signed(m1_tx1_reg);
            m2_ta_next[i] = ta;
            m2_ba_next[i] = ba;
        end
    end

    // The normal term is aligned to 40 fractional bits by a shift of twelve.
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            m3_acc_next[i] = NORM_W'($signed(m2_ta_reg[i])) + NORM_W'($signed(m2_ba_reg[i]))
                           + (NORM_W'($signed(m2_nz_reg[i])) << 12);
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            m1_ts_reg  <= m1_ts_next;
            m1_bs_reg  <= m1_bs_next;
            m1_nz_reg  <= m1_nz_next;
            m1_tx0_reg <= d2_reg[NORM_LAT-1].tx2[0];
            m1_tx1_reg <= d2_reg[NORM_LAT-1].tx2[1];
            m1_tex_reg <= d2_reg[NORM_LAT-1].tex;
            m2_ta_reg  <= m2_ta_next;
            m2_ba_reg  <= m2_ba_next;
            m2_nz_reg  <= m1_nz_reg;
            m2_tex_reg <= m1_tex_reg;
            m3_acc_reg <= m3_acc_next;
            m3_tex_reg <= m2_tex_reg;
        end
    end

    assign na_in = m3_acc_reg;

    tsnm_norm3 u_norm_a (.aclk(aclk), .en(en), .vec_in(na_in), .vec_out(na_out));

    always_ff @(posedge aclk) begin
        if (en) begin
            d3_tex_reg[0] <= m3_tex_reg;
            for (int k = 1; k < NORM_LAT; k++) begin
                d3_tex_reg[k] <= d3_tex_reg[k-1];
            end
            // Disable mode hands the texel back untouched.
            f_res_reg <= cfg.disable_mode ? d3_tex_reg[NORM_LAT-1] : na_out;
        end
    end

    // Output register with a skid register behind it.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg    <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (m_valid_reg && m_ready) begin
            if (skid_valid_reg) begin
                m_valid_reg    <= 1'b1;
                skid_valid_reg <= 1'b0;
            end else begin
                m_valid_reg <= push;
            end
        end else if (!m_valid_reg) begin
            m_valid_reg <= push;
        end else if (push) begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (m_valid_reg && m_ready && skid_valid_reg) begin
            m_res_reg <= skid_res_reg;
        end else if (push && (!m_valid_reg || m_ready)) begin
            m_res_reg <= f_res_reg;
        end else if (push) begin
            skid_res_reg <= f_res_reg;
        end
    end

    assign m_valid    = m_valid_reg;
    assign m_result_x = m_res_reg[0];
    assign m_result_y = m_res_reg[1];
    assign m_result_z = m_res_reg[2];

`ifndef ASSERT_OFF
    a_skid_behind_out: assert property (@(posedge aclk) disable iff (!aresetn)
        skid_valid_reg |-> m_valid_reg)
        else $error("skid register holds a result while the output register is empty");

    a_skid_fill_on_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(skid_valid_reg) |-> $past(m_valid_reg && !m_ready))
        else $error("skid register filled without an output stall");

    a_reset_clears_out: assert property (@(posedge aclk)
        !aresetn |=> (!m_valid_reg && !skid_valid_reg))
        else $error("output buffer not empty after reset");
`endif

endmodule

### dv/tangent_space_normal_map_core_tb.sv
// Self-checking testbench for tangent_space_normal_map_core: random requests against an
// in-bench fixed-point predictor, with random stalls and register settings.
// Depends on tsnm_pkg and the core RTL only.
`timescale 1ns / 100ps

module tangent_space_normal_map_core_tb import tsnm_pkg::*;;

    // One request: texel, surface normal, tangent and bitangent, three components each.
    typedef struct packed {
        logic [2:0][15:0] tex;
        logic [2:0][15:0] nrm;
        logic [2:0][15:0] tan;
        logic [2:0][15:0] bitan;
    } req_t;

    typedef logic [2:0][15:0] res_t;
    typedef longint svec_t [3];

    // Settle time after the last result, well beyond the depth of the pipeline.
    localparam int DRAIN_CYCLES = 400;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [15:0] m_result_x, m_result_y, m_result_z;
    logic        psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [4:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    req_t cur_req = '0;

    // Mirror of the block's register file, kept in step with every APB write.
    logic        mir_disable = 1'b0;
    logic        mir_normal = 1'b1;
    logic        mir_tangent = 1'b1;
    logic        mir_bitangent = 1'b1;
    logic [15:0] mir_scale_x = 16'd4096;
    logic [15:0] mir_scale_y = 16'd4096;
    logic [31:0] mir_epsilon = 32'd16;

    req_t pending_reqs[$];
    res_t expected_normals[$];
    int   gap_left = 0;
    int   stall_left = 0;
    bit   no_idle = 1'b0;
    bit   hold_sender = 1'b0;
    int   n_errors = 0;
    int   n_sent = 0;
    int   n_checked = 0;
    int   n_phases = 0;

    always #5 aclk = ~aclk;

    tangent_space_normal_map_core i_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_texel_x     (cur_req.tex[0]),
        .s_texel_y     (cur_req.tex[1]),
        .s_texel_z     (cur_req.tex[2]),
        .s_normal_x    (cur_req.nrm[0]),
        .s_normal_y    (cur_req.nrm[1]),
        .s_normal_z    (cur_req.nrm[2]),
        .s_tangent_x   (cur_req.tan[0]),
        .s_tangent_y   (cur_req.tan[1]),
        .s_tangent_z   (cur_req.tan[2]),
        .s_bitangent_x (cur_req.bitan[0]),
        .s_bitangent_y (cur_req.bitan[1]),
        .s_bitangent_z (cur_req.bitan[2]),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_result_x    (m_result_x),
        .m_result_y    (m_result_y),
        .m_result_z    (m_result_z),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    // Integer square root, bit by bit, floor of the exact root.
    function automatic longint unsigned isqrt(longint unsigned x);
        longint unsigned r;
        longint unsigned b;
        r = 0;
        b = 64'd1 << 62;
        while (b > x)
            b >>= 2;
        while (b != 0) begin
            if (x >= r + b) begin
                x -= r + b;
                r = (r >> 1) + b;
            end else begin
                r >>= 1;
            end
            b >>= 2;
        end
        return r;
    endfunction

    // Normalises to Q2.14. The magnitudes are first brought to a common scale so that
    // the largest lies in [2^29, 2^30); truncation on the right shift is intended.
    function automatic svec_t norm3(svec_t v);
        longint unsigned mag[3];
        bit              neg[3];
        longint unsigned m, s, len, q;
        svec_t           o;
        m = 0;
        for (int i = 0; i < 3; i++) begin
            neg[i] = v[i] < 0;
            mag[i] = neg[i] ? longint'(-v[i]) : longint'(v[i]);
            if (mag[i] > m)
                m = mag[i];
        end
        if (m == 0)
            return '{0, 0, 0};
        while (m >= (64'd1 << 30)) begin
            for (int i = 0; i < 3; i++)
                mag[i] >>= 1;
            m >>= 1;
        end
        while (m < (64'd1 << 29)) begin
            for (int i = 0; i < 3; i++)
                mag[i] <<= 1;
            m <<= 1;
        end
        s = 0;
        for (int i = 0; i < 3; i++)
            s += mag[i] * mag[i];
        len = isqrt(s);
        for (int i = 0; i < 3; i++) begin
            q = ((mag[i] << 15) + len) / (2 * len);
            if (q > 32767)
                q = 32767;
            o[i] = neg[i] ? -longint'(q) : longint'(q);
        end
        return o;
    endfunction

    // Works out the perturbed normal for one request under the mirrored settings.
    function automatic res_t perturbed_normal(req_t r);
        svec_t           tx, n, t, b, c, acc, o;
        longint unsigned len2;
        longint          sx, sy;
        res_t            res;
        for (int i = 0; i < 3; i++) begin
            tx[i] = longint'($signed(r.tex[i]));
            n[i]  = longint'($signed(r.nrm[i]));
            t[i]  = longint'($signed(r.tan[i]));
            b[i]  = longint'($signed(r.bitan[i]));
        end
        if (mir_disable)
            return r.tex;
        len2 = 0;
        for (int i = 0; i < 3; i++)
            len2 += tx[i] * tx[i];
        // A texel too short to carry a direction falls back to the flat default.
        if (len2 < longint'(mir_epsilon))
            tx = '{longint'(Q14_HALF), longint'(Q14_HALF), longint'(Q14_ONE)};
        sx = longint'($signed(mir_scale_x));
        sy = longint'($signed(mir_scale_y));
        if (mir_normal)
            n = norm3(n);
        if (mir_tangent)
            t = norm3(t);
        if (mir_bitangent) begin
            c[0] = t[1] * n[2] - t[2] * n[1];
            c[1] = t[2] * n[0] - t[0] * n[2];
            c[2] = t[0] * n[1] - t[1] * n[0];
            b = norm3(c);
        end
        for (int i = 0; i < 3; i++)
            tx[i] = 2 * tx[i] - longint'(Q14_ONE);
        // The normal term is scaled by 4096 so that all three share 40 fraction bits.
        for (int i = 0; i < 3; i++)
            acc[i] = t[i] * sx * tx[0] + b[i] * sy * tx[1] + n[i] * tx[2] * 4096;
        o = norm3(acc);
        for (int i = 0; i < 3; i++)
            res[i] = o[i][15:0];
        return res;
    endfunction

    task automatic report_mismatch(string what, logic [15:0] got, logic [15:0] want);
        $display("%0t: mismatch on %s: got %04h, expected %04h", $time, what, got, want);
        n_errors++;
    endtask

    // Mostly short gaps, now and then a long one, none at all in a no-idle stretch.
    function automatic int draw_gap();
        int p;
        p = $urandom_range(0, 99);
        if (no_idle || p < 65)
            return 0;
        if (p < 95)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // Sender: a request is handed over whenever the slot is free and no gap is running.
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                expected_normals.push_back(perturbed_normal(cur_req));
                n_sent++;
            end
            if (!s_valid || s_ready) begin
                if (gap_left > 0) begin
                    gap_left--;
                    s_valid <= 1'b0;
                end else if (!hold_sender && pending_reqs.size() > 0) begin
                    cur_req <= pending_reqs.pop_front();
                    s_valid <= 1'b1;
                    gap_left = draw_gap();
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // Receiver: random back-pressure, and every accepted result is checked in order.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                if (expected_normals.size() == 0) begin
                    $display("%0t: result %04h %04h %04h with no request outstanding",
                             $time, m_result_x, m_result_y, m_result_z);
                    n_errors++;
                end else begin
                    res_t want;
                    want = expected_normals.pop_front();
                    if (m_result_x !== want[0]) report_mismatch("result_x", m_result_x, want[0]);
                    if (m_result_y !== want[1]) report_mismatch("result_y", m_result_y, want[1]);
                    if (m_result_z !== want[2]) report_mismatch("result_z", m_result_z, want[2]);
                    n_checked++;
                end
                stall_left = draw_gap();
            end
            if (stall_left > 0) begin
                stall_left--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    // Two-phase APB write; the register takes the value at the access edge.
    task automatic apb_write(reg_idx_t idx, logic [31:0] value);
        @(posedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_DISABLE:   mir_disable   = value[0];
            REG_NORMAL:    mir_normal    = value[0];
            REG_TANGENT:   mir_tangent   = value[0];
            REG_BITANGENT: mir_bitangent = value[0];
            REG_SCALE_X:   mir_scale_x   = value[15:0];
            REG_SCALE_Y:   mir_scale_y   = value[15:0];
            REG_EPSILON:   mir_epsilon   = value;
            default: ;
        endcase
    endtask

    task automatic set_config(bit dis, bit nrm, bit tan, bit bitan,
                              logic [15:0] sx, logic [15:0] sy, logic [31:0] eps);
        apb_write(REG_DISABLE, {31'd0, dis});
        apb_write(REG_NORMAL, {31'd0, nrm});
        apb_write(REG_TANGENT, {31'd0, tan});
        apb_write(REG_BITANGENT, {31'd0, bitan});
        apb_write(REG_SCALE_X, {16'd0, sx});
        apb_write(REG_SCALE_Y, {16'd0, sy});
        apb_write(REG_EPSILON, eps);
    endtask

    // Waits until every queued request has been sent and has come back out.
    task automatic wait_idle();
        while (pending_reqs.size() > 0 || s_valid || expected_normals.size() > 0)
            @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    function automatic logic [15:0] rnd_unit_comp();
        return 16'($signed($urandom_range(0, 32768)) - 16384);
    endfunction

    // Random requests: mostly plausible normal-map data, the rest raw noise,
    // near-zero texels, degenerate frames and extreme components.
    function automatic req_t random_req();
        req_t r;
        int   kind;
        r = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
        kind = $urandom_range(0, 99);
        if (kind < 60) begin
            for (int i = 0; i < 3; i++) begin
                r.tex[i]   = 16'($urandom_range(0, 16384));
                r.nrm[i]   = rnd_unit_comp();
                r.tan[i]   = rnd_unit_comp();
                r.bitan[i] = rnd_unit_comp();
            end
        end else if (kind < 75) begin
            for (int i = 0; i < 3; i++)
                r.tex[i] = 16'($signed($urandom_range(0, 16)) - 8);
        end else if (kind < 82) begin
            case ($urandom_range(0, 3))
                0: r.nrm = '0;
                1: r.tan = '0;
                2: r.tan = r.nrm;
                default: r.bitan = '0;
            endcase
        end else if (kind < 86) begin
            r.tex[$urandom_range(0, 2)] = $urandom_range(0, 1) ? 16'h8000 : 16'h7FFF;
            r.nrm[$urandom_range(0, 2)] = $urandom_range(0, 1) ? 16'h8000 : 16'h7FFF;
        end
        return r;
    endfunction

    task automatic run_random(int count);
        for (int k = 0; k < count; k++)
            pending_reqs.push_back(random_req());
        wait_idle();
        n_phases++;
    endtask

    task automatic push_req(logic [47:0] tex, logic [47:0] nrm, logic [47:0] tan,
                            logic [47:0] bitan);
        req_t r;
        r.tex = tex;
        r.nrm = nrm;
        r.tan = tan;
        r.bitan = bitan;
        pending_reqs.push_back(r);
    endtask

    initial begin
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed requests under reset settings: flat texel, axis frames, extremes,
        // short texels, zero vectors and a tangent parallel to the normal.
        no_idle = 1'b1;
        push_req({16'd16384, 16'd8192, 16'd8192}, {16'd16384, 16'd0, 16'd0},
                 {16'd0, 16'd0, 16'd16384}, '0);
        push_req({16'd16384, 16'd16384, 16'd16384}, {16'd16384, 16'd0, 16'd0},
                 {16'd0, 16'd0, 16'd16384}, '0);
        push_req('0, {16'd16384, 16'd0, 16'd0}, {16'd0, 16'd0, 16'd16384}, '0);
        push_req({16'd0, 16'd0, 16'd3}, {16'd0, 16'd0, 16'd9000}, {16'd0, 16'd9000, 16'd0}, '0);
        push_req({16'd0, 16'd0, 16'd4}, {16'd0, 16'd0, 16'd9000}, {16'd0, 16'd9000, 16'd0}, '0);
        push_req({3{16'h8000}}, {3{16'h8000}}, {3{16'h8000}}, {3{16'h8000}});
        push_req({3{16'h7FFF}}, {3{16'h7FFF}}, {3{16'h7FFF}}, {3{16'h7FFF}});
        push_req({16'h7FFF, 16'h8000, 16'h7FFF}, {16'h8000, 16'h7FFF, 16'h8000},
                 {16'h7FFF, 16'h7FFF, 16'h8000}, {16'h8000, 16'h8000, 16'h7FFF});
        push_req({16'd16384, 16'd0, 16'd0}, '0, {16'd0, 16'd0, 16'd16384}, '0);
        push_req({16'd16384, 16'd0, 16'd0}, {16'd16384, 16'd0, 16'd0}, '0, '0);
        push_req({16'd16384, 16'd0, 16'd0}, {16'd5, 16'd5, 16'd5}, {16'd5, 16'd5, 16'd5}, '0);
        push_req({16'd8192, 16'd8192, 16'd8192}, {16'd1, 16'd0, 16'd0}, {16'd0, 16'd1, 16'd0}, '0);
        push_req({16'd16384, 16'd0, 16'd16384}, {16'hC000, 16'd0, 16'd0},
                 {16'd0, 16'hC000, 16'd0}, '0);
        wait_idle();
        no_idle = 1'b0;
        run_random(100);

        // Pass-through of the raw texel.
        set_config(1'b1, 1'b1, 1'b1, 1'b1, 16'd4096, 16'd4096, 32'd16);
        run_random(150);

        // Raw frame with the supplied bitangent and the most negative scales.
        set_config(1'b0, 1'b0, 1'b0, 1'b0, 16'h8000, 16'h8000, 32'd0);
        run_random(200);

        // Largest scales, every texel treated as short.
        set_config(1'b0, 1'b1, 1'b0, 1'b1, 16'h7FFF, 16'h7FFF, 32'hFFFF_FFFF);
        run_random(150);

        // Mixed settings, with the sender held part way through so the pipeline empties.
        set_config(1'b0, 1'b0, 1'b1, 1'b1, 16'hF000, 16'd2048, 32'h0040_0000);
        hold_sender = 1'b1;
        for (int k = 0; k < 100; k++)
            pending_reqs.push_back(random_req());
        hold_sender = 1'b0;
        while (pending_reqs.size() > 50)
            @(posedge aclk);
        hold_sender = 1'b1;
        while (s_valid || expected_normals.size() > 0)
            @(posedge aclk);
        hold_sender = 1'b0;
        run_random(150);

        // Random settings, back to full throughput for one stretch.
        for (int p = 0; p < 4; p++) begin
            set_config($urandom_range(0, 9) == 0, $urandom_range(0, 1), $urandom_range(0, 1),
                       $urandom_range(0, 1), 16'($urandom), 16'($urandom),
                       $urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 4096));
            no_idle = (p == 1);
            run_random(150);
        end
        no_idle = 1'b0;

        set_config(1'b0, 1'b1, 1'b1, 1'b1, 16'd4096, 16'd4096, 32'd16);
        run_random(100);

        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (expected_normals.size() > 0) begin
            $display("%0d expected results never arrived", expected_normals.size());
            n_errors += expected_normals.size();
        end
        $display("Sent %0d requests over %0d register settings, checked %0d results.",
                 n_sent, n_phases, n_checked);
        if (n_errors == 0)
            $display("[tangent_space_normal_map_core] OK");
        else
            $display("[tangent_space_normal_map_core] ERROR");
        $finish;
    end

    // Watchdog: far beyond the slowest legal run of this stimulus.
    initial begin
        #20_000_000;
        $display("Timed out with %0d results outstanding", expected_normals.size());
        $display("[tangent_space_normal_map_core] ERROR");
        $finish;
    end

endmodule

### filelist.f
design/tsnm_pkg.sv
design/tsnm_cfg.sv
design/tsnm_norm3.sv
design/tangent_space_normal_map_core.sv
dv/tangent_space_normal_map_core_tb.sv
